// ----- rtl/ted_pkg.sv -----
// types and codes shared by the edge table unit and its testbench
`timescale 1ns / 1ps

package ted_pkg;

  localparam int VERT_W  = 16;
  localparam int SLOT_W  = 10;
  localparam int TOTAL_W = 11;
  localparam int REQ_W   = 2;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
    logic [VERT_W-1:0] vertex_c;
    logic [SLOT_W-1:0] read_slot;
  } ted_in_t;

  typedef struct packed {
    logic [2:0]         new_edge_mask;
    logic [TOTAL_W-1:0] edge_total;
    logic               overflow;
    logic [VERT_W-1:0]  read_first;
    logic [VERT_W-1:0]  read_second;
    logic               read_valid;
  } ted_out_t;

endpackage

// ----- rtl/ted_ram.sv -----
// generic simple dual port ram, one write port and one registered read port
`timescale 1ns / 1ps

module ted_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/triangle_edge_dedup_table_unit.sv -----
// unique undirected edge table built from triangles, with clear and read-back
`timescale 1ns / 1ps

//  channel  | direction | ports                          | transaction
//  ---------+-----------+--------------------------------+------------------------------
//  in       | input     | in_valid, in_stall, in_data    | add triangle, clear or read
//  out      | output    | out_valid, out_stall, out_data | one result per request
//
//  an add request walks the edge memory at most once per candidate edge, one
//  stored entry per cycle through the single comparator and the single read port;
//  a walk ends early at the first stored entry that matches the candidate
//  clear and unused codes go straight to the finish step; a read fetches its slot first
//  reset only clears the edge count and control; the memory needs no sweep
//  in_stall stays high while a request is in progress; a finished result
//  waits in the output register, and the next request is taken meanwhile

module triangle_edge_dedup_table_unit #(
  parameter int MAX_EDGES   = 1024,
  parameter int VERTEX_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ted_pkg::ted_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ted_pkg::ted_out_t out_data
);

  import ted_pkg::*;

  // stored vertex width: ports carry 16 bits, so wider indices never occur
  localparam int VBITS = (VERTEX_BITS < VERT_W) ? VERTEX_BITS : VERT_W;
  localparam int AW    = $clog2(MAX_EDGES);
  localparam int CW    = $clog2(MAX_EDGES + 1);

  // candidate edge codes, in check order
  localparam logic [1:0] CAND_AB = 2'd0;
  localparam logic [1:0] CAND_CB = 2'd1;
  localparam logic [1:0] CAND_AC = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [1:0]        cand_r, cand_nxt;
  logic [2:0]        mask_r, mask_nxt;
  logic              ovf_r, ovf_nxt;
  logic [VBITS-1:0]  va_r, va_nxt;
  logic [VBITS-1:0]  vb_r, vb_nxt;
  logic [VBITS-1:0]  vc_r, vc_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [VBITS-1:0]  rd_first_r, rd_first_nxt;
  logic [VBITS-1:0]  rd_second_r, rd_second_nxt;
  logic              out_valid_r, out_valid_nxt;
  ted_out_t          out_data_r, out_data_nxt;

  // candidate endpoints
  logic [VBITS-1:0]   cand_p, cand_q;
  // memory port signals
  logic               ram_we;
  logic [AW-1:0]      ram_wa;
  logic [AW-1:0]      ram_ra;
  logic [2*VBITS-1:0] ram_wd;
  logic [2*VBITS-1:0] ram_rd;
  logic [VBITS-1:0]   st_first, st_second;
  logic               edge_match;
  logic               table_full;
  logic               in_take;

  assign in_take    = in_valid && !in_stall;
  assign table_full = (count_r == CW'(MAX_EDGES));
  assign st_first   = ram_rd[2*VBITS-1:VBITS];
  assign st_second  = ram_rd[VBITS-1:0];

  always_comb begin
    unique case (cand_r)
      CAND_AB: begin
        cand_p = va_r;
        cand_q = vb_r;
      end
      CAND_CB: begin
        cand_p = vc_r;
        cand_q = vb_r;
      end
      CAND_AC: begin
        cand_p = va_r;
        cand_q = vc_r;
      end
      default: begin
        cand_p = va_r;
        cand_q = vc_r;
      end
    endcase
  end

  // the shared comparator, either orientation
  assign edge_match = ((st_first == cand_p) && (st_second == cand_q)) ||
                      ((st_first == cand_q) && (st_second == cand_p));

  ted_ram #(
    .WIDTH (2 * VBITS),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cand_nxt      = cand_r;
    mask_nxt      = mask_r;
    ovf_nxt       = ovf_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    vc_nxt        = vc_r;
    slot_nxt      = slot_r;
    rd_ok_nxt     = rd_ok_r;
    rd_first_nxt  = rd_first_r;
    rd_second_nxt = rd_second_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_wa        = count_r[AW-1:0];
    ram_wd        = {cand_p, cand_q};
    ram_ra        = idx_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          va_nxt      = in_data.vertex_a[VBITS-1:0];
          vb_nxt      = in_data.vertex_b[VBITS-1:0];
          vc_nxt      = in_data.vertex_c[VBITS-1:0];
          slot_nxt    = in_data.read_slot;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          cand_nxt    = CAND_AB;
          mask_nxt    = '0;
          ovf_nxt     = 1'b0;
          rd_ok_nxt   = 1'b0;
          rd_first_nxt  = '0;
          rd_second_nxt = '0;
          unique case (in_data.req_type)
            REQ_ADD:   state_nxt = ST_SCAN;
            REQ_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_DONE;
            end
            REQ_READ:  state_nxt = ST_RD_ADDR;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        // entry idx_r-1 is compared while entry idx_r is fetched
        priority if (cmp_vld_r && edge_match) begin
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          cand_nxt    = cand_r + 2'd1;
          if (cand_r == CAND_AC) begin
            state_nxt = ST_DONE;
          end
        end else if (idx_r < count_r) begin
          idx_nxt     = idx_r + CW'(1);
          cmp_vld_nxt = 1'b1;
        end else begin
          // walked every stored edge without a hit
          if (table_full) begin
            ovf_nxt = 1'b1;
          end else begin
            ram_we           = 1'b1;
            count_nxt        = count_r + CW'(1);
            mask_nxt[cand_r] = 1'b1;
          end
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          cand_nxt    = cand_r + 2'd1;
          if (cand_r == CAND_AC) begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_RD_ADDR: begin
        ram_ra    = AW'(slot_r);
        rd_ok_nxt = (32'(slot_r) < 32'(count_r));
        state_nxt = ST_RD_DATA;
      end

      ST_RD_DATA: begin
        if (rd_ok_r) begin
          rd_first_nxt  = st_first;
          rd_second_nxt = st_second;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.new_edge_mask = mask_r;
          out_data_nxt.edge_total    = TOTAL_W'(count_r);
          out_data_nxt.overflow      = ovf_r;
          out_data_nxt.read_first    = VERT_W'(rd_first_r);
          out_data_nxt.read_second   = VERT_W'(rd_second_r);
          out_data_nxt.read_valid    = rd_ok_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      cand_r      <= CAND_AB;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      cand_r      <= cand_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mask_r      <= mask_nxt;
    ovf_r       <= ovf_nxt;
    va_r        <= va_nxt;
    vb_r        <= vb_nxt;
    vc_r        <= vc_nxt;
    slot_r      <= slot_nxt;
    rd_ok_r     <= rd_ok_nxt;
    rd_first_r  <= rd_first_nxt;
    rd_second_r <= rd_second_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EDGES))
    else $error("edge count beyond table depth");

  // no write into a full table
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !table_full)
    else $error("edge write while table full");

  // scan pointer stays within the stored edges
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= count_r))
    else $error("scan index past edge count");

  // a clear transaction empties the table at once
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_data.req_type == REQ_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty table");

  // a new result only comes out of the finish step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside finish step");

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the triangle edge dedup table unit
`timescale 1ns / 1ps

module testbench;
  import ted_pkg::*;

  // clock, sizes and run limits
  localparam int     CLK_PERIOD   = 12;
  localparam int     TABLE_DEPTH  = 1024;
  localparam int     HOLD_CYCLES  = 300;
  // slowest add: three full walks of the edge memory plus the control steps
  localparam int     DRAIN_CYCLES = 3 * TABLE_DEPTH + 8;
  localparam longint LIMIT_CYCLES = 12_000_000;
  localparam int     FILL_TRIS    = 342;

  // request code 3 is not decoded by the block; it must leave the table alone
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  // outcome of offering one candidate edge to the shadow table
  typedef enum logic [1:0] {
    EDGE_FOUND,
    EDGE_STORED,
    EDGE_DROPPED
  } edge_outcome_t;

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ted_in_t  in_data  = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ted_out_t out_data;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  triangle_edge_dedup_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // requests waiting to be offered, and replies the shadow table predicts
  ted_in_t  request_backlog[$];
  ted_out_t predicted_replies[$];

  // shadow copy of the edge table, updated in acceptance order
  logic [VERT_W-1:0] shadow_first  [TABLE_DEPTH];
  logic [VERT_W-1:0] shadow_second [TABLE_DEPTH];
  int unsigned       shadow_count = 0;

  // bookkeeping
  int unsigned accepted_total = 0;
  int unsigned stim_total     = 0;
  int unsigned replies_seen   = 0;
  int unsigned mismatch_total = 0;
  int unsigned add_reqs       = 0;
  int unsigned clear_reqs     = 0;
  int unsigned read_reqs      = 0;
  int unsigned spare_reqs     = 0;
  int unsigned overflow_seen  = 0;
  int unsigned valid_reads    = 0;
  int unsigned peak_total     = 0;
  logic        hold_off       = 1'b0;
  // accepted counts at which the long receiver hold-offs begin
  int unsigned hold_marks [2] = '{12, 90};

  // look the edge up in either orientation, append it if absent and room is left
  function automatic edge_outcome_t shadow_insert(logic [VERT_W-1:0] p, logic [VERT_W-1:0] q);
    for (int i = 0; i < shadow_count; i++) begin
      if ((shadow_first[i] == p && shadow_second[i] == q) ||
          (shadow_first[i] == q && shadow_second[i] == p)) begin
        return EDGE_FOUND;
      end
    end
    if (shadow_count >= TABLE_DEPTH) begin
      return EDGE_DROPPED;
    end
    shadow_first[shadow_count]  = p;
    shadow_second[shadow_count] = q;
    shadow_count++;
    return EDGE_STORED;
  endfunction

  // apply one request to the shadow table and return the reply it must produce
  function automatic ted_out_t apply_to_shadow_table(ted_in_t req);
    ted_out_t          reply;
    logic [VERT_W-1:0] cand_p [3];
    logic [VERT_W-1:0] cand_q [3];
    reply  = '0;
    // candidate order matters: ab, then cb, then ac, each seeing the ones before
    cand_p = '{req.vertex_a, req.vertex_c, req.vertex_a};
    cand_q = '{req.vertex_b, req.vertex_b, req.vertex_c};
    case (req.req_type)
      REQ_ADD: begin
        for (int k = 0; k < 3; k++) begin
          case (shadow_insert(cand_p[k], cand_q[k]))
            EDGE_STORED:  reply.new_edge_mask[k] = 1'b1;
            EDGE_DROPPED: reply.overflow = 1'b1;
            default: ;
          endcase
        end
      end
      REQ_CLEAR: begin
        shadow_count = 0;
      end
      REQ_READ: begin
        // slots at or past the count read back as zero with valid low
        if (req.read_slot < shadow_count) begin
          reply.read_first  = shadow_first[req.read_slot];
          reply.read_second = shadow_second[req.read_slot];
          reply.read_valid  = 1'b1;
        end
      end
      default: ;
    endcase
    reply.edge_total = TOTAL_W'(shadow_count);
    return reply;
  endfunction

  task automatic queue_request(input logic [REQ_W-1:0] kind, input logic [VERT_W-1:0] a,
                               input logic [VERT_W-1:0] b, input logic [VERT_W-1:0] c,
                               input logic [SLOT_W-1:0] slot);
    ted_in_t req;
    req.req_type  = kind;
    req.vertex_a  = a;
    req.vertex_b  = b;
    req.vertex_c  = c;
    req.read_slot = slot;
    request_backlog.push_back(req);
    case (kind)
      REQ_ADD:   add_reqs++;
      REQ_CLEAR: clear_reqs++;
      REQ_READ:  read_reqs++;
      default:   spare_reqs++;
    endcase
  endtask

  // unused fields of a request carry random bits so every input bit toggles
  task automatic queue_add(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b,
                           input logic [VERT_W-1:0] c);
    queue_request(REQ_ADD, a, b, c, SLOT_W'($urandom));
  endtask

  task automatic queue_read(input logic [SLOT_W-1:0] slot);
    queue_request(REQ_READ, VERT_W'($urandom), VERT_W'($urandom), VERT_W'($urandom), slot);
  endtask

  task automatic queue_clear();
    queue_request(REQ_CLEAR, VERT_W'($urandom), VERT_W'($urandom), VERT_W'($urandom),
                  SLOT_W'($urandom));
  endtask

  // driver: offers the backlog in bursts of random length with random gaps;
  // the shadow table is stepped at the edge where a transaction is accepted
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_replies.push_back(apply_to_shadow_table(in_data));
        accepted_total <= accepted_total + 1;
      end
      // the payload only moves once the current transaction is gone
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          in_data  <= request_backlog.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            // a quarter of the bursts run straight into the next one
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: a rotating stall pattern, re-drawn now and then, from never to
  // almost always stalled; the hold-off flag overrides it
  logic [15:0] stall_pattern = '0;
  int unsigned pattern_timer = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall     <= 1'b0;
      stall_pattern <= '0;
      pattern_timer <= 0;
    end else begin
      if (pattern_timer == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern <= '0;
          1:       stall_pattern <= 16'($urandom);
          2:       stall_pattern <= 16'($urandom & $urandom);
          default: stall_pattern <= 16'($urandom | $urandom);
        endcase
        pattern_timer <= $urandom_range(20, 200);
      end else begin
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        pattern_timer <= pattern_timer - 1;
      end
      out_stall <= hold_off || stall_pattern[0];
    end
  end

  // long receiver hold-offs while the sender keeps offering, so the block
  // parks a finished result, takes one more request and then stalls its input
  initial begin
    foreach (hold_marks[i]) begin
      while (accepted_total < hold_marks[i]) @(posedge clk);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // monitor: every accepted result is checked against the oldest prediction
  always @(posedge clk) begin
    ted_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      replies_seen <= replies_seen + 1;
      if (predicted_replies.size() == 0) begin
        mismatch_total <= mismatch_total + 1;
        if (mismatch_total < 10) begin
          $display("error: unexpected result at %0t, nothing pending", $realtime);
        end
      end else begin
        want = predicted_replies.pop_front();
        if (want.overflow) overflow_seen <= overflow_seen + 1;
        if (want.read_valid) valid_reads <= valid_reads + 1;
        if (32'(want.edge_total) > peak_total) peak_total <= 32'(want.edge_total);
        if (out_data.new_edge_mask !== want.new_edge_mask ||
            out_data.edge_total    !== want.edge_total    ||
            out_data.overflow      !== want.overflow      ||
            out_data.read_first    !== want.read_first    ||
            out_data.read_second   !== want.read_second   ||
            out_data.read_valid    !== want.read_valid) begin
          mismatch_total <= mismatch_total + 1;
          if (mismatch_total < 10) begin
            $display("error: result %0d at %0t", replies_seen, $realtime);
            $display("  expected mask %b total %0d ovf %b read %h/%h valid %b",
                     want.new_edge_mask, want.edge_total, want.overflow,
                     want.read_first, want.read_second, want.read_valid);
            $display("  actual   mask %b total %0d ovf %b read %h/%h valid %b",
                     out_data.new_edge_mask, out_data.edge_total, out_data.overflow,
                     out_data.read_first, out_data.read_second, out_data.read_valid);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [VERT_W-1:0] pool [6];
    int                clear_in;
    int                pick;
    int                base;
    int                tri_idx;
    logic [VERT_W-1:0] v0;
    logic [VERT_W-1:0] v1;
    logic [VERT_W-1:0] v2;

    // directed: empty table, degenerate corners, reversed and shared edges,
    // reads at the last slot, past the count and after a clear, spare code
    queue_read(10'd0);
    queue_request(REQ_SPARE, 16'h1234, 16'hFEDC, 16'h0F0F, 10'h3FF);
    queue_add(16'h0000, 16'h0000, 16'h0000);
    queue_add(16'hFFFF, 16'hFFFF, 16'h0000);
    queue_add(16'h0001, 16'h0002, 16'h0003);
    queue_add(16'h0003, 16'h0002, 16'h0001);
    queue_add(16'h0002, 16'h0001, 16'h0003);
    queue_add(16'h0005, 16'h0006, 16'h0005);
    queue_add(16'hAAAA, 16'h5555, 16'hFFFF);
    queue_add(16'h5555, 16'hAAAA, 16'h8000);
    queue_read(10'd0);
    queue_read(10'd1);
    queue_read(10'd12);
    queue_read(10'd13);
    queue_read(10'h3FF);
    queue_clear();
    queue_read(10'd0);
    queue_add(16'h0001, 16'h0002, 16'h0003);
    queue_request(REQ_SPARE, 16'hEDCB, 16'h0123, 16'hF0F0, 10'h000);
    queue_clear();

    // small tables: corners drawn from a tiny pool so edges repeat often,
    // with reads, clears and some noise mixed in
    clear_in = 0;
    for (int n = 0; n < 160; n++) begin
      if (clear_in == 0) begin
        queue_clear();
        foreach (pool[i]) pool[i] = VERT_W'($urandom);
        clear_in = $urandom_range(8, 30);
      end else begin
        clear_in--;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          queue_add(pool[$urandom_range(0, 5)], pool[$urandom_range(0, 5)],
                    pool[$urandom_range(0, 5)]);
        end else if (pick < 65) begin
          queue_add(VERT_W'($urandom), VERT_W'($urandom), VERT_W'($urandom));
        end else if (pick < 90) begin
          queue_read(($urandom_range(0, 4) == 0) ? SLOT_W'($urandom)
                                                 : SLOT_W'($urandom_range(0, 24)));
        end else if (pick < 96) begin
          queue_clear();
        end else begin
          queue_request(REQ_SPARE, VERT_W'($urandom), VERT_W'($urandom),
                        VERT_W'($urandom), SLOT_W'($urandom));
        end
      end
    end

    // fill the table with disjoint triangles; the last one stores its first
    // edge in the final slot and drops the other two
    queue_clear();
    base = $urandom_range(0, 65535 - 3 * FILL_TRIS);
    for (int k = 0; k < FILL_TRIS; k++) begin
      queue_add(VERT_W'(base + 3 * k), VERT_W'(base + 3 * k + 1), VERT_W'(base + 3 * k + 2));
      if (k % 16 == 15) queue_read(SLOT_W'($urandom));
    end

    // full table: known edges still match, new ones are dropped, and a
    // dropped edge does not stop later candidates from matching
    for (int n = 0; n < 20; n++) begin
      tri_idx = $urandom_range(0, FILL_TRIS - 2);
      v0 = VERT_W'(base + 3 * tri_idx);
      v1 = VERT_W'(base + 3 * tri_idx + 1);
      v2 = VERT_W'(base + 3 * tri_idx + 2);
      case ($urandom_range(0, 3))
        0:       queue_add(v2, v1, v0);
        1:       queue_add(v0, v1, VERT_W'($urandom));
        2:       queue_add(VERT_W'($urandom), v1, v2);
        default: queue_add(VERT_W'($urandom), VERT_W'($urandom), VERT_W'($urandom));
      endcase
      if (n % 2 == 1) queue_read(SLOT_W'($urandom));
    end

    // empty again and reuse the low slots
    queue_clear();
    for (int n = 0; n < 5; n++) begin
      queue_add(VERT_W'($urandom_range(0, 3)), VERT_W'($urandom_range(0, 3)),
                VERT_W'($urandom_range(0, 3)));
      queue_read(SLOT_W'($urandom_range(0, 6)));
    end
    stim_total = request_backlog.size();

    // reset, held from time zero and released at a clock edge
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_total < stim_total) @(posedge clk);
    while (predicted_replies.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d adds, %0d clears, %0d reads and %0d spare-code requests",
             add_reqs, clear_reqs, read_reqs, spare_reqs);
    $display("%0d results checked, table peaked at %0d edges, %0d overflows, %0d valid reads",
             replies_seen, peak_total, overflow_seen, valid_reads);
    if (mismatch_total == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatch_total);
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("simulation failed");
    $finish;
  end

endmodule
